[hw/rtl/u8d_pkg.sv]
// shared types, constants and codes of the utf-8 to utf-16 bmp decoder
package u8d_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned CP_W     = 21;
  localparam int unsigned STATUS_W = 3;

  // output tdata layout: code_unit, status, unit_count, padded to bytes
  localparam int unsigned OUT_DATA_BITS = UNIT_W + STATUS_W + UNIT_W;
  localparam int unsigned OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  // limit after reset
  localparam logic [UNIT_W-1:0] LIMIT_RESET = 16'd50;

  // byte classification masks and patterns
  localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
  localparam logic [BYTE_W-1:0] PAT_LEAD2  = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
  localparam logic [BYTE_W-1:0] PAT_LEAD3  = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
  localparam logic [BYTE_W-1:0] PAT_LEAD4  = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
  localparam logic [BYTE_W-1:0] PAT_CONT   = 8'h80;
  localparam logic [CP_W-1:0]   BMP_MAX    = 21'h00FFFF;

  // string status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_LEAD   = 3'd1,
    ST_BAD_CONT   = 3'd2,
    ST_FULL       = 3'd3,
    ST_BEYOND_BMP = 3'd4
  } status_t;

  // decoder state carried between words
  typedef struct packed {
    logic [CP_W-1:0]   partial_cp;
    logic [1:0]        bytes_remaining;
    logic [UNIT_W-1:0] units_emitted;
    status_t           status;
  } dec_state_t;

  // one result word
  typedef struct packed {
    logic [UNIT_W-1:0]   code_unit;
    logic                unit_valid;
    logic                string_done;
    logic [STATUS_W-1:0] status;
    logic [UNIT_W-1:0]   unit_count;
  } result_t;

  // output buffer status toward the top level
  typedef struct packed {
    logic can_push;
    logic main_valid;
  } buf_status_t;

endpackage

[hw/rtl/u8d_step.sv]
// next-state and result logic for one utf-8 byte
module u8d_step (
  input  u8d_pkg::dec_state_t        state_cur,
  input  logic [u8d_pkg::BYTE_W-1:0] byte_value,
  input  logic                       last_byte,
  input  logic [u8d_pkg::UNIT_W-1:0] output_limit,
  output u8d_pkg::dec_state_t        state_nxt,
  output logic                       res_valid,
  output u8d_pkg::result_t           res
);

  logic                       finished;
  logic                       emit;
  logic [u8d_pkg::UNIT_W-1:0] unit;
  u8d_pkg::dec_state_t        st;

  // decode the byte against the current state
  always_comb begin
    st       = state_cur;
    finished = 1'b0;
    emit     = 1'b0;
    unit     = '0;
    if (state_cur.status == u8d_pkg::ST_OK) begin
      if (state_cur.bytes_remaining == 2'd0) begin
        // lead position
        if (!byte_value[7]) begin
          st.partial_cp = {13'd0, byte_value};
          finished      = 1'b1;
        end else if ((byte_value & u8d_pkg::MASK_LEAD2) == u8d_pkg::PAT_LEAD2) begin
          st.partial_cp      = {16'd0, byte_value[4:0]};
          st.bytes_remaining = 2'd1;
        end else if ((byte_value & u8d_pkg::MASK_LEAD3) == u8d_pkg::PAT_LEAD3) begin
          st.partial_cp      = {17'd0, byte_value[3:0]};
          st.bytes_remaining = 2'd2;
        end else if ((byte_value & u8d_pkg::MASK_LEAD4) == u8d_pkg::PAT_LEAD4) begin
          st.partial_cp      = {18'd0, byte_value[2:0]};
          st.bytes_remaining = 2'd3;
        end else begin
          st.status = u8d_pkg::ST_BAD_LEAD;
        end
      end else begin
        // continuation position
        if ((byte_value & u8d_pkg::MASK_CONT) != u8d_pkg::PAT_CONT) begin
          st.status          = u8d_pkg::ST_BAD_CONT;
          st.bytes_remaining = 2'd0;
        end else begin
          st.partial_cp      = {state_cur.partial_cp[u8d_pkg::CP_W-7:0], byte_value[5:0]};
          st.bytes_remaining = state_cur.bytes_remaining - 2'd1;
          finished           = (st.bytes_remaining == 2'd0);
        end
      end
      // finished code point: limit check first, then plane check
      if (finished) begin
        if (st.units_emitted >= output_limit) begin
          st.status = u8d_pkg::ST_FULL;
        end else if (st.partial_cp > u8d_pkg::BMP_MAX) begin
          st.status = u8d_pkg::ST_BEYOND_BMP;
        end else begin
          unit             = st.partial_cp[u8d_pkg::UNIT_W-1:0];
          emit             = 1'b1;
          st.units_emitted = st.units_emitted + 16'd1;
        end
        st.partial_cp = '0;
      end
      // string ends inside a sequence
      if (last_byte && (st.status == u8d_pkg::ST_OK) && (st.bytes_remaining != 2'd0)) begin
        st.status = u8d_pkg::ST_BAD_CONT;
      end
    end
  end

  // result word and state for the next byte
  always_comb begin
    res_valid       = emit | last_byte;
    res.code_unit   = unit;
    res.unit_valid  = emit;
    res.string_done = last_byte;
    res.status      = last_byte ? st.status : u8d_pkg::ST_OK;
    res.unit_count  = last_byte ? st.units_emitted : '0;
    if (last_byte) begin
      state_nxt = '0;
    end else begin
      state_nxt = st;
    end
  end

endmodule

[hw/rtl/u8d_out_buf.sv]
// result register with skid stage toward the output channel
module u8d_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  u8d_pkg::result_t     push_res,
  input  logic                 pop_ready,
  output u8d_pkg::buf_status_t buf_status,
  output u8d_pkg::result_t     head_res
);

  logic             main_valid_r, main_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  u8d_pkg::result_t main_r, main_nxt;
  u8d_pkg::result_t skid_r, skid_nxt;
  logic             pop;

  assign pop = main_valid_r & pop_ready;

  // buffer next state
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign buf_status.can_push   = ~skid_valid_r;
  assign buf_status.main_valid = main_valid_r;
  assign head_res              = main_r;

endmodule

[hw/rtl/utf8_to_utf16_bmp_decoder.sv]
// top level of the utf-8 to utf-16 bmp decoder
//
//  channel | direction | tdata                     | tuser      | tlast
//  in_     | slave     | byte_value                | -          | last_byte
//  out_    | master    | code_unit,status,unit_cnt | unit_valid | string_done
//  cfg_    | write     | output_limit              | -          | -
//
// one byte word is accepted every cycle while in_tready is high; its result word is
// computed by the single decode stage between the state register and the result
// register and is registered there, or in the skid stage when the output stalls.
// a byte that ends no code point and is not the last gives no result word.
// reset clears the decoder state and sets output_limit to 50.
// an output stall is absorbed by a skid stage; in_tready falls only when both
// the result register and the skid stage hold words.
module utf8_to_utf16_bmp_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  // byte_value[7:0]
  input  logic [u8d_pkg::BYTE_W-1:0]     in_tdata,
  input  logic                           in_tlast,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // code_unit[15:0], status[18:16], unit_count[34:19], zero pad above
  output logic [u8d_pkg::OUT_DATA_W-1:0] out_tdata,
  // unit_valid[0]
  output logic                           out_tuser,
  output logic                           out_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_we,
  input  logic [u8d_pkg::UNIT_W-1:0]     cfg_wdata
);

  logic [u8d_pkg::UNIT_W-1:0] limit_r;
  u8d_pkg::dec_state_t        state_r;
  u8d_pkg::dec_state_t        state_nxt;
  logic                       res_valid;
  u8d_pkg::result_t           res;
  u8d_pkg::result_t           head_res;
  u8d_pkg::buf_status_t       buf_status;
  logic                       in_acc;

  assign in_tready = buf_status.can_push;
  assign in_acc    = in_tvalid & in_tready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= u8d_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // decode stage
  u8d_step u_step (
    .state_cur    (state_r),
    .byte_value   (in_tdata),
    .last_byte    (in_tlast),
    .output_limit (limit_r),
    .state_nxt    (state_nxt),
    .res_valid    (res_valid),
    .res          (res)
  );

  // decoder state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // result register and skid stage
  u8d_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_acc & res_valid),
    .push_res   (res),
    .pop_ready  (out_tready),
    .buf_status (buf_status),
    .head_res   (head_res)
  );

  // output packing
  assign out_tvalid = buf_status.main_valid;
  assign out_tlast  = head_res.string_done;
  assign out_tuser  = head_res.unit_valid;
  assign out_tdata  = {{(u8d_pkg::OUT_DATA_W - u8d_pkg::OUT_DATA_BITS){1'b0}},
                       head_res.unit_count, head_res.status, head_res.code_unit};

  // a full skid stage implies a full result register
  assert property (@(posedge clk) disable iff (!rst_n) !in_tready |-> out_tvalid)
    else $error("skid stage holds a word while result register is empty");

  // the last byte of a string leaves a cleared state behind
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (state_r.units_emitted == '0 &&
                              state_r.status == u8d_pkg::ST_OK &&
                              state_r.bytes_remaining == 2'd0))
    else $error("state not cleared after last byte");

  // a latched error never leaves a sequence open
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.status != u8d_pkg::ST_OK) |-> (state_r.bytes_remaining == 2'd0))
    else $error("error latched with continuation bytes pending");

endmodule

[tb/tb_utf8_to_utf16_bmp_decoder.sv]
// self-checking testbench for the utf-8 to utf-16 bmp decoder
module tb_utf8_to_utf16_bmp_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import u8d_pkg::*;

  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned PHASE_BYTES    = 120;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned STEADY_PHASE   = 2;

  typedef enum logic {ROW_BYTE, ROW_LIMIT} row_kind_t;

  // one row of the directed plan: a byte word or a limit write
  typedef struct {
    row_kind_t   kind;
    logic [15:0] val;
    bit          last;
    bit          typed;
    result_t     res;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic [BYTE_W-1:0]     in_tdata;
  logic                  in_tlast;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we;
  logic [UNIT_W-1:0]     cfg_wdata;

  // decoder state as predicted
  logic [15:0] unit_limit;
  logic [20:0] code_point;
  logic [1:0]  conts_left;
  logic [15:0] units_out;
  status_t     string_status;

  result_t     expected_units[$];
  plan_row_t   plan[$];
  logic [7:0]  str_bytes[$];
  int unsigned bad_words = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  bit          steady = 1'b0;

  utf8_to_utf16_bmp_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // decode one byte word; returns 1 when it yields a result word
  function automatic bit decode_byte(input logic [7:0] b, input bit last, output result_t r);
    bit          done_cp;
    bit          emit;
    logic [15:0] unit;
    done_cp = 1'b0;
    emit    = 1'b0;
    unit    = '0;
    r       = '0;
    if (string_status == ST_OK) begin
      if (conts_left == 2'd0) begin
        // lead position
        casez (b)
          8'b0???????: begin
            code_point = {13'd0, b};
            done_cp    = 1'b1;
          end
          8'b110?????: begin
            code_point = {16'd0, b[4:0]};
            conts_left = 2'd1;
          end
          8'b1110????: begin
            code_point = {17'd0, b[3:0]};
            conts_left = 2'd2;
          end
          8'b11110???: begin
            code_point = {18'd0, b[2:0]};
            conts_left = 2'd3;
          end
          default: string_status = ST_BAD_LEAD;
        endcase
      end else if (b[7:6] != 2'b10) begin
        string_status = ST_BAD_CONT;
        conts_left    = 2'd0;
      end else begin
        code_point = {code_point[14:0], b[5:0]};
        conts_left = conts_left - 2'd1;
        done_cp    = (conts_left == 2'd0);
      end
      // a finished code point: limit check first, then the plane check
      if (done_cp) begin
        if (units_out >= unit_limit) begin
          string_status = ST_FULL;
        end else if (code_point[20:16] != 5'd0) begin
          string_status = ST_BEYOND_BMP;
        end else begin
          unit      = code_point[15:0];
          emit      = 1'b1;
          units_out = units_out + 16'd1;
        end
        code_point = '0;
      end
      // string ends inside a sequence
      if (last && string_status == ST_OK && conts_left != 2'd0) begin
        string_status = ST_BAD_CONT;
      end
    end
    if (!emit && !last) begin
      return 1'b0;
    end
    r.code_unit   = emit ? unit : 16'd0;
    r.unit_valid  = emit;
    r.string_done = last;
    r.status      = last ? string_status : ST_OK;
    r.unit_count  = last ? units_out : 16'd0;
    if (last) begin
      code_point    = '0;
      conts_left    = '0;
      units_out     = '0;
      string_status = ST_OK;
    end
    return 1'b1;
  endfunction

  // directed plan rows
  function automatic void plan_byte(input logic [7:0] b, input bit last);
    plan_row_t row;
    row = '{kind: ROW_BYTE, val: {8'd0, b}, last: last, typed: 1'b0, res: '0};
    plan.push_back(row);
  endfunction

  function automatic void plan_fixed(input logic [7:0] b, input bit last,
                                     input logic [15:0] unit, input bit valid,
                                     input bit done, input status_t st,
                                     input logic [15:0] count);
    plan_row_t row;
    row = '{kind: ROW_BYTE, val: {8'd0, b}, last: last, typed: 1'b1, res: '0};
    row.res.code_unit   = unit;
    row.res.unit_valid  = valid;
    row.res.string_done = done;
    row.res.status      = st;
    row.res.unit_count  = count;
    plan.push_back(row);
  endfunction

  function automatic void plan_limit(input logic [15:0] v);
    plan_row_t row;
    row = '{kind: ROW_LIMIT, val: v, last: 1'b0, typed: 1'b0, res: '0};
    plan.push_back(row);
  endfunction

  // random string building
  function automatic void put_char(input int len, input int conts);
    logic [31:0] rnd;
    logic [7:0]  lead;
    rnd = $urandom;
    case (len)
      1:       lead = {1'b0, rnd[6:0]};
      2:       lead = {3'b110, rnd[4:0]};
      3:       lead = {4'b1110, rnd[3:0]};
      default: lead = {5'b11110, rnd[2:0]};
    endcase
    str_bytes.push_back(lead);
    repeat (conts) begin
      rnd = $urandom;
      str_bytes.push_back({2'b10, rnd[5:0]});
    end
  endfunction

  function automatic int pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 1;
    if (r < 60) return 2;
    if (r < 85) return 3;
    return 4;
  endfunction

  // send one byte word, with an optional gap before it
  task automatic send_byte(input logic [7:0] b, input bit last, input bit fixed,
                           input result_t fixed_res);
    int unsigned gap;
    result_t     r;
    bit          has;
    gap = (!steady && $urandom_range(0, 99) < 8) ? $urandom_range(1, 5) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = b;
    in_tlast  = last;
    in_tvalid = 1'b1;
    forever begin
      @(posedge clk);
      if (in_tready === 1'b1) break;
    end
    has = decode_byte(b, last, r);
    if (fixed) begin
      expected_units.push_back(fixed_res);
    end else if (has) begin
      expected_units.push_back(r);
    end
    bytes_sent++;
  endtask

  // write the limit once the decoder has gone quiet
  task automatic set_limit(input logic [15:0] v);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_units.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we     = 1'b0;
    unit_limit = v;
  endtask

  // one random string: mostly well formed, some with an error, some noise
  task automatic send_string();
    int unsigned mode;
    int          nchars;
    int          err_at;
    int          len;
    logic [31:0] rnd;
    str_bytes.delete();
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      repeat ($urandom_range(1, 8)) str_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      nchars = $urandom_range(1, 10);
      err_at = (mode < 30) ? $urandom_range(0, nchars) : -1;
      for (int k = 0; k < nchars; k++) begin
        if (k == err_at) begin
          rnd = $urandom;
          if (rnd[8]) begin
            // bad lead byte
            str_bytes.push_back(rnd[9] ? {2'b10, rnd[5:0]} : {5'b11111, rnd[2:0]});
          end else begin
            // sequence broken by a non-continuation byte
            len = $urandom_range(2, 4);
            put_char(len, $urandom_range(0, len - 2));
            str_bytes.push_back(rnd[9] ? {1'b0, rnd[6:0]} : {2'b11, rnd[5:0]});
          end
        end
        len = pick_len();
        put_char(len, len - 1);
      end
      // truncated sequence at the end of the string
      if (err_at == nchars) begin
        len = $urandom_range(2, 4);
        put_char(len, $urandom_range(0, len - 2));
      end
    end
    foreach (str_bytes[i]) begin
      send_byte(str_bytes[i], i == str_bytes.size() - 1, 1'b0, '0);
    end
  endtask

  // result side backpressure
  always @(negedge clk) begin
    out_tready = steady ? 1'b1 : ($urandom_range(0, 99) >= 20);
  end

  // result word checking
  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got.code_unit   = out_tdata[15:0];
      got.status      = out_tdata[18:16];
      got.unit_count  = out_tdata[34:19];
      got.unit_valid  = out_tuser;
      got.string_done = out_tlast;
      if (expected_units.size() == 0) begin
        if (bad_words < 10) begin
          $display("unexpected word: unit=%h valid=%b done=%b status=%0d count=%0d",
                   got.code_unit, got.unit_valid, got.string_done, got.status,
                   got.unit_count);
        end
        bad_words++;
      end else begin
        want = expected_units.pop_front();
        if (got !== want) begin
          if (bad_words < 10) begin
            $display("mismatch: expected unit=%h valid=%b done=%b status=%0d count=%0d",
                     want.code_unit, want.unit_valid, want.string_done, want.status,
                     want.unit_count);
            $display("          got      unit=%h valid=%b done=%b status=%0d count=%0d",
                     got.code_unit, got.unit_valid, got.string_done, got.status,
                     got.unit_count);
          end
          bad_words++;
        end
      end
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("[utf8_to_utf16_bmp_decoder] ERROR");
      $finish;
    end
  end

  // reset, directed plan, random phases, drain
  initial begin
    logic [15:0] phase_limit;
    int unsigned phase_start;
    rst_n         = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    in_tvalid     = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    unit_limit    = 16'd50;
    code_point    = '0;
    conts_left    = '0;
    units_out     = '0;
    string_status = ST_OK;

    // directed plan: extremes, every sequence length and every error
    plan_fixed(8'h00, 1'b0, 16'h0000, 1'b1, 1'b0, ST_OK, 16'd0);
    plan_fixed(8'h7F, 1'b1, 16'h007F, 1'b1, 1'b1, ST_OK, 16'd2);
    plan_byte(8'hC2, 1'b0);
    plan_byte(8'h80, 1'b1);
    plan_byte(8'hEF, 1'b0);
    plan_byte(8'hBF, 1'b0);
    plan_byte(8'hBF, 1'b1);
    plan_byte(8'hF0, 1'b0);
    plan_byte(8'h90, 1'b0);
    plan_byte(8'h80, 1'b0);
    plan_fixed(8'h80, 1'b1, 16'h0000, 1'b0, 1'b1, ST_BEYOND_BMP, 16'd0);
    plan_fixed(8'hFF, 1'b1, 16'h0000, 1'b0, 1'b1, ST_BAD_LEAD, 16'd0);
    plan_byte(8'hC3, 1'b0);
    plan_fixed(8'h41, 1'b1, 16'h0000, 1'b0, 1'b1, ST_BAD_CONT, 16'd0);
    plan_byte(8'hE2, 1'b0);
    plan_fixed(8'h82, 1'b1, 16'h0000, 1'b0, 1'b1, ST_BAD_CONT, 16'd0);
    plan_byte(8'hC0, 1'b0);
    plan_byte(8'h80, 1'b1);
    // continuation byte in lead position, then bytes ignored after the error
    plan_byte(8'h80, 1'b0);
    plan_byte(8'h41, 1'b0);
    plan_fixed(8'hC2, 1'b1, 16'h0000, 1'b0, 1'b1, ST_BAD_LEAD, 16'd0);
    plan_limit(16'd0);
    plan_fixed(8'h41, 1'b1, 16'h0000, 1'b0, 1'b1, ST_FULL, 16'd0);
    // limit raised inside one string, then rewritten with the same value
    plan_limit(16'd1);
    plan_byte(8'h41, 1'b0);
    plan_limit(16'd2);
    plan_byte(8'h42, 1'b0);
    plan_limit(16'd2);
    plan_fixed(8'h43, 1'b1, 16'h0000, 1'b0, 1'b1, ST_FULL, 16'd2);
    plan_limit(16'hFFFF);

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_LIMIT) begin
        set_limit(plan[i].val);
      end else begin
        send_byte(plan[i].val[7:0], plan[i].last, plan[i].typed, plan[i].res);
      end
    end

    // random phases, each under its own limit
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       phase_limit = 16'hFFFF;
        1:       phase_limit = 16'd3;
        2:       phase_limit = 16'($urandom_range(0, 65535));
        3:       phase_limit = 16'd0;
        4:       phase_limit = 16'd1;
        5:       phase_limit = 16'($urandom_range(2, 20));
        6:       phase_limit = 16'd50;
        default: phase_limit = 16'hFFFF;
      endcase
      set_limit(phase_limit);
      steady      = (ph == STEADY_PHASE);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_string();
    end
    steady = 1'b0;

    // drain
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_words == 0 && expected_units.size() == 0) begin
      $display("[utf8_to_utf16_bmp_decoder] OK");
    end else begin
      $display("[utf8_to_utf16_bmp_decoder] ERROR");
    end
    $finish;
  end

endmodule
